// ----- rtl/core/tbb_pkg.sv -----
// Shared types and constants of the tile binning bounding box unit.
package tbb_pkg;

    localparam int COORD_W = 16;
    localparam int TAG_W   = 16;
    localparam int FRAME_W = 10;
    localparam int PAD_W   = 6;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int TILE_W  = 3;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 4;
    localparam int CMP_W   = 12;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_PAD    = 2'd2;

    localparam logic [FRAME_W-1:0] FRAME_RESET = 10'd512;
    localparam logic [PAD_W-1:0]   PAD_RESET   = 6'd1;

    typedef struct packed {
        logic load;
        logic calc;
        logic emit;
    } t_tbb_cmd;

    typedef struct packed {
        logic empty;
        logic last;
        logic out_free;
    } t_tbb_sts;

endpackage

// ----- rtl/core/tbb_datapath.sv -----
// Datapath: config registers, box clamp and tile range, tile scan counters, output register.
module tbb_datapath #(
    parameter int TILE_PIXELS   = 64,
    parameter int MAX_TILE_COLS = 8,
    parameter int MAX_TILE_ROWS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbb_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [tbb_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  tbb_pkg::t_tbb_cmd                 i_cmd,
    output tbb_pkg::t_tbb_sts                 o_sts,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [tbb_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                              o_m_tlast
);
    import tbb_pkg::*;

    localparam int TS_LOG2 = $clog2(TILE_PIXELS);

    logic [FRAME_W-1:0] r_frame_w, r_frame_h;
    logic [PAD_W-1:0]   r_pad;

    logic signed [COORD_W-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic [TAG_W-1:0]          r_tag;

    logic [TILE_W-1:0]  r_cs, r_ce, r_rs, r_re, r_row, r_col;
    logic [COUNT_W-1:0] r_cols;
    logic               r_empty;

    logic               r_out_valid;
    logic [TILE_W-1:0]  r_out_row, r_out_col;
    logic [INDEX_W-1:0] r_out_index;
    logic [TAG_W-1:0]   r_out_tag;
    logic               r_out_last;

    function automatic logic [FRAME_W-1:0] clamp_edge(input logic signed [COORD_W:0] v,
                                                      input logic [FRAME_W-1:0] hi);
        logic [FRAME_W-1:0] res;
        if (v[COORD_W]) begin
            res = '0;
        end else if (v[COORD_W-1:0] > {{(COORD_W-FRAME_W){1'b0}}, hi}) begin
            res = hi;
        end else begin
            res = v[FRAME_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [COUNT_W-1:0] tile_count(input logic [FRAME_W-1:0] size,
                                                      input logic [CMP_W-1:0] cap);
        logic [FRAME_W:0]   sum;
        logic [CMP_W-1:0]   cnt;
        logic [COUNT_W-1:0] res;
        sum = {1'b0, size} + (FRAME_W+1)'(TILE_PIXELS - 1);
        cnt = CMP_W'(sum[FRAME_W:TS_LOG2]);
        if (cnt > cap) begin
            res = cap[COUNT_W-1:0];
        end else begin
            res = cnt[COUNT_W-1:0];
        end
        return res;
    endfunction

    logic signed [COORD_W:0] v_cs, v_rs, v_ce, v_re;
    logic [FRAME_W-1:0]      k_cs, k_rs, k_ce, k_re;
    logic [CMP_W-1:0]        ts_cs, ts_rs, ts_ce, ts_re, ce_cap, re_cap, lim_c, lim_r;
    logic [COUNT_W-1:0]      cols, rows;
    logic                    n_empty;

    assign v_cs = $signed({r_min_x[COORD_W-1], r_min_x}) - $signed({11'd0, r_pad});
    assign v_rs = $signed({r_min_y[COORD_W-1], r_min_y}) - $signed({11'd0, r_pad});
    assign v_ce = $signed({r_max_x[COORD_W-1], r_max_x}) + $signed({11'd0, r_pad});
    assign v_re = $signed({r_max_y[COORD_W-1], r_max_y}) + $signed({11'd0, r_pad});

    assign k_cs = clamp_edge(v_cs, r_frame_w);
    assign k_rs = clamp_edge(v_rs, r_frame_h);
    assign k_ce = clamp_edge(v_ce, r_frame_w);
    assign k_re = clamp_edge(v_re, r_frame_h);

    assign ts_cs = CMP_W'(k_cs[FRAME_W-1:TS_LOG2]);
    assign ts_rs = CMP_W'(k_rs[FRAME_W-1:TS_LOG2]);
    assign ts_ce = CMP_W'(k_ce[FRAME_W-1:TS_LOG2]);
    assign ts_re = CMP_W'(k_re[FRAME_W-1:TS_LOG2]);

    assign cols  = tile_count(r_frame_w, CMP_W'(MAX_TILE_COLS));
    assign rows  = tile_count(r_frame_h, CMP_W'(MAX_TILE_ROWS));
    assign lim_c = CMP_W'(cols) - CMP_W'(1);
    assign lim_r = CMP_W'(rows) - CMP_W'(1);

    assign ce_cap = (ts_ce > lim_c) ? lim_c : ts_ce;
    assign re_cap = (ts_re > lim_r) ? lim_r : ts_re;

    assign n_empty = (cols == '0) || (rows == '0) || (ts_cs > ce_cap) || (ts_rs > re_cap);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= FRAME_RESET;
            r_frame_h <= FRAME_RESET;
            r_pad     <= PAD_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data[FRAME_W-1:0];
                CFG_BOUND_PAD:    r_pad     <= i_cfg_data[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture, range setup, scan counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_min_x <= i_s_tdata[15:0];
            r_min_y <= i_s_tdata[31:16];
            r_max_x <= i_s_tdata[47:32];
            r_max_y <= i_s_tdata[63:48];
            r_tag   <= i_s_tdata[79:64];
        end
        if (i_cmd.calc) begin
            r_cs    <= ts_cs[TILE_W-1:0];
            r_rs    <= ts_rs[TILE_W-1:0];
            r_ce    <= ce_cap[TILE_W-1:0];
            r_re    <= re_cap[TILE_W-1:0];
            r_row   <= ts_rs[TILE_W-1:0];
            r_col   <= ts_cs[TILE_W-1:0];
            r_cols  <= cols;
            r_empty <= n_empty;
        end else if (i_cmd.emit) begin
            if (r_col == r_ce) begin
                r_col <= r_cs;
                r_row <= r_row + TILE_W'(1);
            end else begin
                r_col <= r_col + TILE_W'(1);
            end
        end
    end

    logic [6:0] idx_full;
    assign idx_full = 7'(r_row) * 7'(r_cols) + 7'(r_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_index <= idx_full[INDEX_W-1:0];
            r_out_tag   <= r_tag;
            r_out_last  <= o_sts.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.empty    = r_empty;
    assign o_sts.last     = (r_row == r_re) && (r_col == r_ce);
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_tag, r_out_index, r_out_col, r_out_row};
    assign o_m_tlast  = r_out_last;

endmodule

// ----- rtl/core/tbb_ctrl.sv -----
// Controller: request accept, range setup and tile scan sequencing.
module tbb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  tbb_pkg::t_tbb_sts  i_sts,
    output tbb_pkg::t_tbb_cmd  o_cmd
);
    import tbb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_SCAN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.empty) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/tile_bin_bounding_box_unit.sv -----
// Top level of the tile binning bounding box unit.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/tready         tdata: min_x, min_y, max_x, max_y, tag
//  m_axis   out  m_axis_tvalid/tready         tdata: row, col, index, tag; tlast
//  cfg      in   i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// A request is handled in order: capture, then clamp and tile range, then one tile per
// cycle from the scan counters for each of the N covered tiles (1..64); when no tile is
// covered the scan ends without output. A stalled output holds the scan. The next
// request is taken while the last tile still waits in the output register. Reset is
// synchronous, active low.
module tile_bin_bounding_box_unit #(
    parameter int TILE_PIXELS   = 64,
    parameter int MAX_TILE_COLS = 8,
    parameter int MAX_TILE_ROWS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // min_x[15:0], min_y[31:16], max_x[47:32], max_y[63:48], primitive_tag[79:64]
    input  logic [tbb_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tile_row[2:0], tile_col[5:3], tile_index[11:6], tag_out[27:12], zero[31:28]
    output logic [tbb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_wr_en,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tbb_pkg::CFG_W-1:0]          i_cfg_data
);
    import tbb_pkg::*;

    t_tbb_cmd cmd;
    t_tbb_sts sts;

    tbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tbb_datapath #(
        .TILE_PIXELS   (TILE_PIXELS),
        .MAX_TILE_COLS (MAX_TILE_COLS),
        .MAX_TILE_ROWS (MAX_TILE_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule
